>>> hdl/icph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_pkg: shared types and helpers for the internet checksum block
// Queue entry layout and ones' complement arithmetic.
// ----------------------------------------------------------------------------
package icph_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] MASK16 = 16'hffff;
    localparam logic [7:0]  PAD_LOW = 8'h00;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
        logic [15:0] pseudo_sum;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'h0000, s[16]};
        return f[15:0];
    endfunction

    // Fold a plain sum of up to eight 16-bit words into 16 bits with end-around carry.
    function automatic logic [15:0] oc_fold19(input logic [18:0] t);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, t[15:0]} + {14'h0000, t[18:16]};
        f2 = {1'b0, f1[15:0]} + {16'h0000, f1[16]};
        return f2[15:0];
    endfunction

endpackage

>>> hdl/icph_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_front: byte pairing front end
// Pairs bytes into 16-bit words, pads an odd final byte, and sums the
// pseudo-header words for the last word of a packet.
// ----------------------------------------------------------------------------
module icph_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_last_byte,
    input  logic                  s_include_pseudo,
    input  logic [31:0]           s_source_address,
    input  logic [31:0]           s_destination_address,
    input  logic [7:0]            s_protocol_number,
    input  logic [15:0]           s_upper_length,
    input  logic                  q_full,
    output logic                  q_push,
    output icph_pkg::entry_t      q_entry
);

    logic       odd_reg;
    logic       odd_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;
    logic [18:0] pseudo_total;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (odd_reg || s_last_byte);

    assign pseudo_total = {3'b000, s_source_address[31:16]}
                        + {3'b000, s_source_address[15:0]}
                        + {3'b000, s_destination_address[31:16]}
                        + {3'b000, s_destination_address[15:0]}
                        + {11'h000, s_protocol_number}
                        + {3'b000, s_upper_length};

    always_comb begin
        q_entry.word       = odd_reg ? {held_reg, s_data_byte} : {s_data_byte, icph_pkg::PAD_LOW};
        q_entry.last       = s_last_byte;
        q_entry.pseudo_sum = (s_last_byte && s_include_pseudo) ?
                             icph_pkg::oc_fold19(pseudo_total) : 16'h0000;
    end

    always_comb begin
        odd_next  = odd_reg;
        held_next = held_reg;
        if (accept) begin
            if (odd_reg || s_last_byte) begin
                odd_next = 1'b0;
            end else begin
                odd_next  = 1'b1;
                held_next = s_data_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odd_reg <= 1'b0;
        end else begin
            odd_reg <= odd_next;
        end
        held_reg <= held_next;
    end

endmodule

>>> hdl/icph_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_queue: short register queue between front and back
// First-in first-out store of word entries.
// ----------------------------------------------------------------------------
module icph_queue #(
    parameter int DEPTH = icph_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int WIDTH = icph_pkg::ENTRY_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    output logic             rd_valid,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/icph_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_back: ones' complement accumulator and result register
// Adds one word per cycle while the queue has one and, for a last word, the
// result register is free; on the last word adds the pseudo-header sum and
// registers the complemented checksum.
module icph_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_pop,
    input  icph_pkg::entry_t q_entry,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_checksum
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_sum_reg;
    logic [15:0] out_sum_next;
    logic [15:0] word_sum;
    logic        out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = q_valid && (!q_entry.last || out_free);
    assign word_sum = icph_pkg::oc_add(sum_reg, q_entry.word);

    always_comb begin
        sum_next       = sum_reg;
        out_sum_next   = out_sum_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (q_pop) begin
            if (q_entry.last) begin
                sum_next       = 16'h0000;
                out_sum_next   = ~icph_pkg::oc_add(word_sum, q_entry.pseudo_sum)
                                 & icph_pkg::MASK16;
                out_valid_next = 1'b1;
            end else begin
                sum_next = word_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= 16'h0000;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
        out_sum_reg <= out_sum_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_checksum = out_sum_reg;

endmodule

>>> hdl/internet_checksum_pseudo_header.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header: streaming internet checksum
// Path: last word goes through the queue register, then the result register.
// Throughput: one byte item per cycle while the queue is not full; a stalled
// result holds only the next last word.
// Reset: synchronous, active low; clears pairing, sum, queue and output valid.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header #(
    parameter int QUEUE_DEPTH = icph_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        s_include_pseudo,
    input  logic [31:0] s_source_address,
    input  logic [31:0] s_destination_address,
    input  logic [7:0]  s_protocol_number,
    input  logic [15:0] s_upper_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_checksum
);

    logic             q_full;
    logic             q_push;
    logic             q_valid;
    logic             q_pop;
    icph_pkg::entry_t wr_entry;
    icph_pkg::entry_t rd_entry;

    icph_front u_front (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_data_byte           (s_data_byte),
        .s_last_byte           (s_last_byte),
        .s_include_pseudo      (s_include_pseudo),
        .s_source_address      (s_source_address),
        .s_destination_address (s_destination_address),
        .s_protocol_number     (s_protocol_number),
        .s_upper_length        (s_upper_length),
        .q_full                (q_full),
        .q_push                (q_push),
        .q_entry               (wr_entry)
    );

    icph_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (icph_pkg::ENTRY_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_push),
        .wr_data  (wr_entry),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_data  (rd_entry)
    );

    icph_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_entry    (rd_entry),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_checksum (m_checksum)
    );

endmodule

>>> bench/tb_internet_checksum_pseudo_header.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_internet_checksum_pseudo_header: self-checking bench for the checksum
// Feeds packets one byte per item and checks every checksum against a local
// ones' complement model. It covers odd lengths, carry wrap, pseudo-header
// sums, idle and stall patterns on both channels, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_internet_checksum_pseudo_header;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        s_include_pseudo;
    logic [31:0] s_source_address;
    logic [31:0] s_destination_address;
    logic [7:0]  s_protocol_number;
    logic [15:0] s_upper_length;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_checksum;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    int error_count = 0;
    int stuck_cycles = 0;

    // checksum model state
    logic [15:0] sum_acc   = 16'h0000;
    logic        odd_pos   = 1'b0;
    logic [7:0]  held_byte = 8'h00;
    logic [15:0] checksum_q[$];

    internet_checksum_pseudo_header u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_data_byte          (s_data_byte),
        .s_last_byte          (s_last_byte),
        .s_include_pseudo     (s_include_pseudo),
        .s_source_address     (s_source_address),
        .s_destination_address(s_destination_address),
        .s_protocol_number    (s_protocol_number),
        .s_upper_length       (s_upper_length),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_checksum           (m_checksum)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        t = {1'b0, t[15:0]} + {16'h0000, t[16]};
        return t[15:0];
    endfunction

    function automatic void absorb_byte(input logic [7:0] data, input logic is_last,
                                        input logic pseudo, input logic [31:0] src,
                                        input logic [31:0] dst, input logic [7:0] proto,
                                        input logic [15:0] ulen);
        logic [15:0] total;
        if (odd_pos) begin
            sum_acc   = ones_add(sum_acc, {held_byte, data});
            odd_pos   = 1'b0;
            held_byte = 8'h00;
        end else if (is_last) begin
            sum_acc = ones_add(sum_acc, {data, 8'h00});
        end else begin
            held_byte = data;
            odd_pos   = 1'b1;
        end
        if (is_last) begin
            total = sum_acc;
            if (pseudo) begin
                total = ones_add(total, src[31:16]);
                total = ones_add(total, src[15:0]);
                total = ones_add(total, dst[31:16]);
                total = ones_add(total, dst[15:0]);
                total = ones_add(total, {8'h00, proto});
                total = ones_add(total, ulen);
            end
            checksum_q.push_back(~total);
            sum_acc   = 16'h0000;
            odd_pos   = 1'b0;
            held_byte = 8'h00;
        end
    endfunction

    // results checked before new bytes are absorbed, plus the stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (checksum_q.size() == 0) begin
                $display("%0t: unexpected checksum, expected none, actual %h",
                         $time, m_checksum);
                error_count++;
            end else begin
                if (m_checksum !== checksum_q[0]) begin
                    $display("%0t: checksum mismatch, expected %h, actual %h",
                             $time, checksum_q[0], m_checksum);
                    error_count++;
                end
                void'(checksum_q.pop_front());
            end
        end
        if (aresetn && s_valid && s_ready) begin
            absorb_byte(s_data_byte, s_last_byte, s_include_pseudo, s_source_address,
                        s_destination_address, s_protocol_number, s_upper_length);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, stuck_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic is_last, input logic pseudo,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic [7:0] proto, input logic [15:0] ulen);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data_byte           = data;
        s_last_byte           = is_last;
        s_include_pseudo      = pseudo;
        s_source_address      = src;
        s_destination_address = dst;
        s_protocol_number     = proto;
        s_upper_length        = ulen;
        s_valid               = 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
    endtask

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // zero sum gives all ones
        send_byte(8'h00, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
        // single odd byte, pseudo fields all zero
        send_byte(8'hff, 1'b1, 1'b1, 32'h0, 32'h0, 8'h00, 16'h0000);
        // sum of all ones gives zero
        send_byte(8'hff, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
        send_byte(8'hff, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
        // odd length, zero pad
        send_byte(8'h12, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
        send_byte(8'h34, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
        send_byte(8'h56, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
        // pseudo-header at its maximum, repeated carries
        send_byte(8'hff, 1'b0, 1'b1, 32'hffffffff, 32'hffffffff, 8'hff, 16'hffff);
        send_byte(8'hff, 1'b1, 1'b1, 32'hffffffff, 32'hffffffff, 8'hff, 16'hffff);
        // pseudo fields on unused bytes are ignored
        send_byte(8'ha5, 1'b0, 1'b1, 32'hdeadbeef, 32'h01234567, 8'h11, 16'h1234);
        send_byte(8'h5a, 1'b0, 1'b1, 32'hffffffff, 32'hffffffff, 8'hff, 16'hffff);
        send_byte(8'h80, 1'b0, 1'b0, 32'h12345678, 32'h9abcdef0, 8'h06, 16'h0014);
        send_byte(8'h01, 1'b1, 1'b0, 32'hffffffff, 32'hffffffff, 8'hff, 16'hffff);
        // typical TCP segment, odd length
        send_byte(8'h45, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
        send_byte(8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
        send_byte(8'h73, 1'b1, 1'b1, 32'hc0a80001, 32'hc0a800c7, 8'h06, 16'h0003);
        // one-byte UDP payload
        send_byte(8'h7f, 1'b1, 1'b1, 32'h0a000001, 32'h0a0000fe, 8'h11, 16'h0000);
    endtask

    task automatic run_packets(input int n_items, input int tx_pct, input int rx_pct);
        int sent;
        int len;
        int style;
        logic pseudo;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0] proto;
        logic [15:0] ulen;
        logic [7:0] data;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            style  = int'($urandom_range(9));
            len    = (style == 0) ? int'($urandom_range(200, 64)) : int'($urandom_range(24, 1));
            pseudo = 1'($urandom_range(1));
            src    = $urandom;
            dst    = $urandom;
            proto  = 8'($urandom);
            ulen   = 16'($urandom);
            if (style == 3) begin
                src   = 32'hffffffff;
                dst   = 32'hffffffff;
                proto = 8'hff;
                ulen  = 16'hffff;
            end
            for (int i = 0; i < len; i++) begin
                case (style)
                    1: begin
                        data = 8'hff;
                    end
                    2: begin
                        data = 8'h00;
                    end
                    default: begin
                        data = 8'($urandom);
                    end
                endcase
                if (i == len - 1) begin
                    send_byte(data, 1'b1, pseudo, src, dst, proto, ulen);
                end else begin
                    send_byte(data, 1'b0, 1'($urandom_range(1)), $urandom, $urandom,
                              8'($urandom), 16'($urandom));
                end
            end
            sent += len;
        end
    endtask

    // output held off while two-byte packets keep coming, so the input stalls
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_byte(8'($urandom), i[0], 1'($urandom_range(1)), $urandom, $urandom,
                      8'($urandom), 16'($urandom));
        end
        while (!hold_done) @(negedge aclk);
        hold_req = 1'b0;
    endtask

    initial begin
        aresetn               = 1'b0;
        s_valid               = 1'b0;
        s_data_byte           = 8'h00;
        s_last_byte           = 1'b0;
        s_include_pseudo      = 1'b0;
        s_source_address      = 32'h0;
        s_destination_address = 32'h0;
        s_protocol_number     = 8'h00;
        s_upper_length        = 16'h0000;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        run_packets(270, 10, 53);
        run_packets(270, 53, 10);
        test_backpressure();
        run_packets(270, 0, 0);

        @(negedge aclk);
        s_valid = 1'b0;
        while (checksum_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
